/* sv/bpr_pkg.sv */
// Shared types and constants for the button press / repeat event machine.
`timescale 1ns / 1ps

package bpr_pkg;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_DEBOUNCE = 3'd1,
      PH_PRESSED  = 3'd2,
      PH_REPEAT   = 3'd3,
      PH_RELEASE  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PRESS   = 3'd1,
      EV_LONG    = 3'd2,
      EV_REPEAT  = 3'd3,
      EV_RELEASE = 3'd4
   } event_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EVENT_ENABLE = 3'd4;

   localparam logic [15:0] DEBOUNCE_RESET     = 16'd20;
   localparam logic [15:0] LONG_PRESS_RESET   = 16'd500;
   localparam logic [15:0] REPEAT_RESET       = 16'd300;
   localparam logic [3:0]  REPEAT_LIMIT_RESET = 4'd10;
   localparam logic [3:0]  EVENT_ENABLE_RESET = 4'hF;

   localparam int EN_PRESS   = 0;
   localparam int EN_LONG    = 1;
   localparam int EN_REPEAT  = 2;
   localparam int EN_RELEASE = 3;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] long_press_ms;
      logic [15:0] repeat_ms;
      logic [3:0]  repeat_limit;
      logic [3:0]  event_enable;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] mark_time;
      logic [3:0]  repeat_counter;
   } state_type;

endpackage

/* sv/bpr_step.sv */
// Next-state and event logic for one pin sample.
`timescale 1ns / 1ps

module bpr_step
   import bpr_pkg::*;
(
   input  state_type   state,
   input  cfg_type     cfg,
   input  logic        pin_level,
   input  logic [31:0] now_ms,
   output state_type   state_next,
   output event_type   event_code
);

   logic        pressed;
   logic [31:0] delta;
   logic        debounce_done;
   logic        long_done;
   logic        repeat_done;

   assign pressed       = !pin_level;
   assign delta         = now_ms - state.mark_time;
   assign debounce_done = delta > {16'd0, cfg.debounce_ms};
   assign long_done     = delta > {16'd0, cfg.long_press_ms};
   assign repeat_done   = delta > {16'd0, cfg.repeat_ms};

   always_comb begin
      state_next = state;
      event_code = EV_NONE;
      case (state.phase)
         PH_IDLE: begin
            if (pressed) begin
               state_next.phase     = PH_DEBOUNCE;
               state_next.mark_time = now_ms;
            end
         end
         PH_DEBOUNCE: begin
            if (debounce_done) begin
               if (pressed) begin
                  state_next.phase     = PH_PRESSED;
                  state_next.mark_time = now_ms;
                  if (cfg.event_enable[EN_PRESS]) event_code = EV_PRESS;
               end else begin
                  state_next.phase = PH_IDLE;
               end
            end
         end
         PH_PRESSED: begin
            if (!pressed) begin
               state_next.phase = PH_IDLE;
            end else if (long_done) begin
               state_next.phase          = PH_REPEAT;
               state_next.mark_time      = now_ms;
               state_next.repeat_counter = '0;
               if (cfg.event_enable[EN_LONG]) event_code = EV_LONG;
            end
         end
         PH_REPEAT: begin
            if (!pressed) begin
               state_next.phase = PH_RELEASE;
            end else if (repeat_done) begin
               state_next.mark_time = now_ms;
               if (cfg.event_enable[EN_REPEAT]) begin
                  event_code = EV_REPEAT;
                  if (state.repeat_counter < cfg.repeat_limit) begin
                     state_next.repeat_counter = state.repeat_counter + 4'd1;
                  end
               end
            end
         end
         PH_RELEASE: begin
            if (repeat_done) begin
               state_next.mark_time = now_ms;
               if (cfg.event_enable[EN_RELEASE]) begin
                  event_code = EV_RELEASE;
                  if (state.repeat_counter != 4'd0) begin
                     state_next.repeat_counter = state.repeat_counter - 4'd1;
                  end else begin
                     state_next.phase = PH_IDLE;
                  end
               end else begin
                  state_next.phase = PH_IDLE;
               end
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

/* sv/button_press_repeat_fsm.sv */
// Top level of the button press / long-press / repeat / release event machine.
`timescale 1ns / 1ps
//
// Usage:
//   req_*  : one transaction per pin poll (active-low pin level, ms timestamp).
//   rsp_*  : exactly one transaction per poll: event code, phase after the
//            poll and repeat counter after the poll.
//   csr_*  : register write port, index 0..4 in the order debounce, long press,
//            repeat spacing, repeat limit, event enable; writes take effect at
//            once; the user, not the block, makes sure no poll is in flight.
// Pipeline: an accepted poll is held in the input register and evaluated
//   against the machine state; its result is registered in the result
//   register when it advances, and rsp_valid rises with it.
// Throughput: one poll per cycle while rsp_ready stays high; the single
//   next-state evaluation sets it. Reset: synchronous; registers return to
//   20/500/300/10/0xF, the machine to idle with mark time and counter zero, both stages empty.
// Stall: while rsp_ready is low the result register holds; one more poll may
//   wait in the input register, then req_ready drops.

module button_press_repeat_fsm
   import bpr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_pin_level,
   input  logic [31:0]            req_now_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_event_code,
   output logic [2:0]             rsp_phase,
   output logic [3:0]             rsp_repeat_level,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type     cfg_ff;
   state_type   state_ff;
   state_type   state_in;
   event_type   event_in;
   logic        in_valid_ff;
   logic        in_pin_ff;
   logic [31:0] in_now_ff;
   logic        rsp_valid_ff;
   event_type   rsp_event_ff;
   phase_type   rsp_phase_ff;
   logic [3:0]  rsp_level_ff;
   logic        advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
         cfg_ff.repeat_ms     <= REPEAT_RESET;
         cfg_ff.repeat_limit  <= REPEAT_LIMIT_RESET;
         cfg_ff.event_enable  <= EVENT_ENABLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE:     cfg_ff.debounce_ms   <= csr_wdata;
            CSR_LONG_PRESS:   cfg_ff.long_press_ms <= csr_wdata;
            CSR_REPEAT:       cfg_ff.repeat_ms     <= csr_wdata;
            CSR_REPEAT_LIMIT: cfg_ff.repeat_limit  <= csr_wdata[3:0];
            CSR_EVENT_ENABLE: cfg_ff.event_enable  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_pin_ff <= req_pin_level;
         in_now_ff <= req_now_ms;
      end
   end

   bpr_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .pin_level  (in_pin_ff),
      .now_ms     (in_now_ff),
      .state_next (state_in),
      .event_code (event_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_IDLE;
         state_ff.mark_time      <= '0;
         state_ff.repeat_counter <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_event_ff <= event_in;
         rsp_phase_ff <= state_in.phase;
         rsp_level_ff <= state_in.repeat_counter;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_code   = rsp_event_ff;
   assign rsp_phase        = rsp_phase_ff;
   assign rsp_repeat_level = rsp_level_ff;

   // press event always lands in the pressed phase
   a_press_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_code == EV_PRESS) |-> (rsp_phase == PH_PRESSED))
      else $error("press event outside pressed phase");

   // long press enters repeat with a cleared counter
   a_long_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_code == EV_LONG)
      |-> (rsp_phase == PH_REPEAT && rsp_repeat_level == 4'd0))
      else $error("long press without repeat entry");

   // machine state moves only when a transaction is evaluated
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a transaction");

endmodule
